// ===== rtl/ffpa_pkg.sv =====
// Shared types and constants for the first-fit pool allocator.
`timescale 1ns / 1ps
package ffpa_pkg;

   // Fixed sizes of the pool arithmetic.
   localparam int unsigned CSR_AW = 3;
   localparam logic [16:0] POOL_MAX_BYTES = 17'd65536;
   localparam logic [16:0] RESET_BYTES = 17'd65536;
   localparam logic [16:0] RESET_USED = 17'd16;
   localparam logic [16:0] MIN_POOL_BYTES = 17'd24;
   localparam logic [15:0] FIRST_OFFSET = 16'd8;
   localparam logic [3:0] MAX_KIND = 4'd3;

   // Request kinds.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE = 1'b1;

   // Register indexes, taken from paddr[2].
   localparam logic REG_POOL_BASE = 1'b0;
   localparam logic REG_POOL_BYTES = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] req_size;
      logic [3:0]  block_type;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] result_address;
      logic [16:0] used_total;
      logic [16:0] peak_used;
   } rsp_type;

   // One entry of the header table.
   typedef struct packed {
      logic [15:0] off;
      logic [16:0] len;
      logic [1:0]  kind;
   } hdr_type;

   localparam int unsigned HDR_W = $bits(hdr_type);

   // Pool configuration as seen by the controller.
   typedef struct packed {
      logic [31:0] pool_base;
      logic [16:0] pool_bytes;
      logic        pool_ok;
      logic        init;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_SHIFT,
      ST_FIN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/first_fit_pool_allocator_top.sv =====
// Top level of the first-fit pool allocator: header walk, table shifting and results.
`timescale 1ns / 1ps
// The allocator keeps its header table in one synchronous RAM and handles one
// transaction at a time. A request walks the live headers one per cycle; an
// allocation that inserts a header, or a free that removes one, then moves every
// header above that point by one RAM slot at one per cycle. The walk and the move
// together cover at most hdr_count slots. Requests rejected up front (invalid
// pool, zero size, bad type, null address) go straight to the result without a
// table access. After reset and after every register write the pool is
// reinitialised in the ST_INIT state, during which no request is taken. A finished
// result waits in an output register, so a new request may be taken while it is
// still stalled.
module first_fit_pool_allocator_top #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ffpa_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ffpa_pkg::rsp_type           rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ffpa_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import ffpa_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   cfg_type cfg;

   state_type state_ff, state_in;

   req_type     req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [16:0] used_ff, used_in;
   logic [16:0] peak_ff, peak_in;
   logic [16:0] need_ff, need_in;
   logic [31:0] tgt_ff, tgt_in;
   logic        ok_ff, ok_in;
   logic [31:0] res_addr_ff, res_addr_in;

   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [CW-1:0] ev_idx_ff, ev_idx_in;
   logic [15:0]   prev_off_ff, prev_off_in;
   logic [16:0]   prev_len_ff, prev_len_in;

   logic          sh_go_ff, sh_go_in;
   logic          sh_up_ff, sh_up_in;
   logic [CW-1:0] sh_src_ff, sh_src_in;
   logic [CW-1:0] sh_last_ff, sh_last_in;
   logic          wq_vld_ff, wq_vld_in;
   logic [CW-1:0] wq_addr_ff, wq_addr_in;

   logic          fin_we_ff, fin_we_in;
   logic [CW-1:0] fin_addr_ff, fin_addr_in;
   hdr_type       fin_data_ff, fin_data_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff, rsp_vld_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   hdr_type       ram_wdata, ram_rdata;
   logic [HDR_W-1:0] ram_rd_bits;

   logic    accept, pre_fail, rsp_load, is_alloc;
   hdr_type cur;
   logic    at_end, fits, hit, walk_stop, walk_ok, walk_shift;
   logic [16:0] next_off;
   logic [18:0] hole;
   logic [CW-1:0] idx_m1;
   logic [15:0] new_off;

   ffpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ffpa_ram #(
      .WIDTH (HDR_W),
      .DEPTH (MAX_BLOCKS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rdata = hdr_type'(ram_rd_bits);
   assign cur = ram_rdata;
   assign is_alloc = (req_ff.action == ACT_ALLOC);
   assign accept = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_vld_ff || !rsp_stall);

   // Requests that fail before any table access.
   always_comb begin
      if (req_payload.action == ACT_ALLOC) begin
         pre_fail = !cfg.pool_ok || (req_payload.req_size == '0) ||
                    (req_payload.block_type > MAX_KIND);
      end else begin
         pre_fail = !cfg.pool_ok || (req_payload.block_address == '0);
      end
   end

   // Evaluation of one header of the walk; the entry at hdr_count is the end marker.
   always_comb begin
      at_end = (ev_idx_ff == cnt_ff);
      next_off = at_end ? (cfg.pool_bytes - 17'd8) : {1'b0, cur.off};
      hole = {2'b00, next_off} - {3'b000, prev_off_ff} - {2'b00, prev_len_ff};
      fits = (ev_idx_ff != '0) && (hole[18] || (hole[17:0] >= {1'b0, need_ff}));
      hit = !at_end && ({16'd0, cur.off} == tgt_ff);
      walk_stop = ev_vld_ff && (is_alloc ? (fits || at_end) : (hit || at_end));
      if (is_alloc) begin
         walk_ok = fits && ((prev_len_ff == '0) || (cnt_ff != CNT_MAX));
         walk_shift = prev_len_ff != '0;
      end else begin
         walk_ok = hit;
         walk_shift = ev_idx_ff != '0;
      end
      idx_m1 = ev_idx_ff - CNT_ONE;
      new_off = (prev_len_ff == '0) ? prev_off_ff : 16'(prev_off_ff + prev_len_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (cfg.init) begin
               state_in = ST_INIT;
            end else if (accept) begin
               state_in = pre_fail ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               if (!walk_ok) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = walk_shift ? ST_SHIFT : ST_FIN;
               end
            end
         end
         ST_SHIFT: begin
            if (!sh_go_ff && !wq_vld_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
      if (cfg.init) begin
         state_in = ST_INIT;
      end
   end

   // Handshake and RAM port controls.
   always_comb begin
      req_stall = (state_ff != ST_IDLE) || cfg.init;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re = 1'b0;
      ram_raddr = '0;
      unique case (state_ff)
         ST_INIT: begin
            ram_we = 1'b1;
            ram_wdata = '{off: FIRST_OFFSET, len: '0, kind: '0};
         end
         ST_WALK: begin
            ram_re = rd_idx_ff < cnt_ff;
            ram_raddr = rd_idx_ff[AW-1:0];
         end
         ST_SHIFT: begin
            ram_re = sh_go_ff;
            ram_raddr = sh_src_ff[AW-1:0];
            ram_we = wq_vld_ff;
            ram_waddr = wq_addr_ff[AW-1:0];
            ram_wdata = ram_rdata;
         end
         ST_FIN: begin
            ram_we = fin_we_ff;
            ram_waddr = fin_addr_ff[AW-1:0];
            ram_wdata = fin_data_ff;
         end
         ST_IDLE, ST_DONE: begin
            ram_we = 1'b0;
         end
         default: ram_we = 1'b0;
      endcase
   end

   // Datapath registers.
   always_comb begin
      req_in = req_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      peak_in = peak_ff;
      need_in = need_ff;
      tgt_in = tgt_ff;
      ok_in = ok_ff;
      res_addr_in = res_addr_ff;
      rd_idx_in = rd_idx_ff;
      ev_vld_in = 1'b0;
      ev_idx_in = rd_idx_ff;
      prev_off_in = prev_off_ff;
      prev_len_in = prev_len_ff;
      sh_go_in = sh_go_ff;
      sh_up_in = sh_up_ff;
      sh_src_in = sh_src_ff;
      sh_last_in = sh_last_ff;
      wq_vld_in = 1'b0;
      wq_addr_in = wq_addr_ff;
      fin_we_in = fin_we_ff;
      fin_addr_in = fin_addr_ff;
      fin_data_in = fin_data_ff;
      rsp_in = rsp_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;

      // Pool reinitialisation.
      if (state_ff == ST_INIT) begin
         cnt_in = CNT_ONE;
         used_in = RESET_USED;
         peak_in = RESET_USED;
      end

      // Capture a new transaction.
      if ((state_ff == ST_IDLE) && accept) begin
         req_in = req_payload;
         need_in = ({1'b0, req_payload.req_size} + 17'd15) & ~17'd7;
         tgt_in = req_payload.block_address - 32'd8 - cfg.pool_base;
         ok_in = 1'b0;
         rd_idx_in = '0;
         fin_we_in = 1'b0;
         sh_go_in = 1'b0;
      end

      // Header walk: one read issued and one entry evaluated per cycle.
      if (state_ff == ST_WALK) begin
         ev_vld_in = 1'b1;
         if (rd_idx_ff < cnt_ff) begin
            rd_idx_in = rd_idx_ff + CNT_ONE;
         end
         if (ev_vld_ff) begin
            prev_off_in = cur.off;
            prev_len_in = cur.len;
         end
         if (walk_stop) begin
            ok_in = walk_ok;
            if (walk_ok && is_alloc) begin
               used_in = used_ff + need_ff;
               if ((used_ff + need_ff) > peak_ff) begin
                  peak_in = used_ff + need_ff;
               end
               res_addr_in = cfg.pool_base + {16'd0, new_off} + 32'd8;
               fin_we_in = 1'b1;
               fin_data_in = '{off: new_off, len: need_ff, kind: req_ff.block_type[1:0]};
               if (prev_len_ff == '0) begin
                  fin_addr_in = idx_m1;
               end else begin
                  fin_addr_in = ev_idx_ff;
                  cnt_in = cnt_ff + CNT_ONE;
                  sh_go_in = ev_idx_ff < cnt_ff;
                  sh_up_in = 1'b1;
                  sh_src_in = cnt_ff - CNT_ONE;
                  sh_last_in = ev_idx_ff;
               end
            end else if (walk_ok) begin
               used_in = used_ff - cur.len;
               if (ev_idx_ff == '0) begin
                  fin_we_in = 1'b1;
                  fin_addr_in = '0;
                  fin_data_in = '{off: FIRST_OFFSET, len: '0, kind: '0};
               end else begin
                  cnt_in = cnt_ff - CNT_ONE;
                  sh_go_in = (ev_idx_ff + CNT_ONE) < cnt_ff;
                  sh_up_in = 1'b0;
                  sh_src_in = ev_idx_ff + CNT_ONE;
                  sh_last_in = cnt_ff - CNT_ONE;
               end
            end
         end
      end

      // Table shift: read one slot, write it one place up or down next cycle.
      if ((state_ff == ST_SHIFT) && sh_go_ff) begin
         wq_vld_in = 1'b1;
         wq_addr_in = sh_up_ff ? (sh_src_ff + CNT_ONE) : (sh_src_ff - CNT_ONE);
         if (sh_src_ff == sh_last_ff) begin
            sh_go_in = 1'b0;
         end else begin
            sh_src_in = sh_up_ff ? (sh_src_ff - CNT_ONE) : (sh_src_ff + CNT_ONE);
         end
      end

      // Result into the output register.
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
         rsp_in.status = !ok_ff;
         rsp_in.result_address = (ok_ff && is_alloc) ? res_addr_ff : '0;
         rsp_in.used_total = used_ff;
         rsp_in.peak_used = peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rsp_vld_ff <= 1'b0;
         ev_vld_ff <= 1'b0;
         wq_vld_ff <= 1'b0;
         sh_go_ff <= 1'b0;
         cnt_ff <= CNT_ONE;
         used_ff <= RESET_USED;
         peak_ff <= RESET_USED;
      end else begin
         state_ff <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         ev_vld_ff <= ev_vld_in;
         wq_vld_ff <= wq_vld_in;
         sh_go_ff <= sh_go_in;
         cnt_ff <= cnt_in;
         used_ff <= used_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      need_ff <= need_in;
      tgt_ff <= tgt_in;
      ok_ff <= ok_in;
      res_addr_ff <= res_addr_in;
      rd_idx_ff <= rd_idx_in;
      ev_idx_ff <= ev_idx_in;
      prev_off_ff <= prev_off_in;
      prev_len_ff <= prev_len_in;
      sh_up_ff <= sh_up_in;
      sh_src_ff <= sh_src_in;
      sh_last_ff <= sh_last_in;
      wq_addr_ff <= wq_addr_in;
      fin_we_ff <= fin_we_in;
      fin_addr_ff <= fin_addr_in;
      fin_data_ff <= fin_data_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // The table always holds at least the first header and never more than its depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && (cnt_ff <= CNT_MAX))
      else $error("header count out of range");

   // The watermark never falls below the current usage.
   a_peak: assert property (@(posedge clock) disable iff (reset)
      used_ff <= peak_ff)
      else $error("peak below used total");

   // A result appears only when a transaction has finished.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("result without finished transaction");

   // The table is never written while the block waits for a request.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("table write while idle");

endmodule

// ===== rtl/ffpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module ffpa_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ffpa_csr.sv =====
// Configuration registers and pool validity check for the allocator.
`timescale 1ns / 1ps
module ffpa_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ffpa_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output ffpa_pkg::cfg_type             cfg
);
   import ffpa_pkg::*;

   logic [31:0] base_ff;
   logic [31:0] base_in;
   logic [16:0] bytes_ff;
   logic [16:0] bytes_in;
   logic        wr_strobe;

   assign wr_strobe = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write decode.
   always_comb begin
      base_in = base_ff;
      bytes_in = bytes_ff;
      if (wr_strobe) begin
         unique case (paddr[2])
            REG_POOL_BASE:  base_in = pwdata;
            REG_POOL_BYTES: bytes_in = pwdata[16:0];
            default:        base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         bytes_ff <= RESET_BYTES;
      end else begin
         base_ff <= base_in;
         bytes_ff <= bytes_in;
      end
   end

   // Read data.
   always_comb begin
      unique case (paddr[2])
         REG_POOL_BASE:  prdata = base_ff;
         REG_POOL_BYTES: prdata = {15'd0, bytes_ff};
         default:        prdata = '0;
      endcase
   end

   // Every write reinitialises the pool; the check covers a non-zero base, alignment and size limits.
   always_comb begin
      cfg.pool_base = base_ff;
      cfg.pool_bytes = bytes_ff;
      cfg.pool_ok = (base_ff != '0) && (base_ff[2:0] == 3'd0) && (bytes_ff[2:0] == 3'd0) &&
                    (bytes_ff >= MIN_POOL_BYTES) && (bytes_ff <= POOL_MAX_BYTES);
      cfg.init = wr_strobe;
   end

endmodule
